// ===== design/kss_pkg.sv =====
// package for the keyed size statistics table
// types and codes shared by the table modules; no dependencies
package kss_pkg;

  typedef enum logic [2:0] {
    ST_NEW   = 3'd0,
    ST_UPD   = 3'd1,
    ST_FULL  = 3'd2,
    ST_DUMP  = 3'd3,
    ST_EMPTY = 3'd4
  } status_e;

  typedef enum logic [0:0] {
    FN_RECORD = 1'b0,
    FN_DUMP   = 1'b1
  } func_e;

  typedef struct packed {
    logic [0:0]  func;
    logic [63:0] stack_id;
    logic [47:0] chunk_size;
  } in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [63:0] entry_key;
    logic [31:0] entry_count;
    logic [63:0] entry_total;
    logic [47:0] entry_min;
    logic [47:0] entry_max;
    logic        last;
  } out_t;

  // one table record as stored in memory
  typedef struct packed {
    logic [63:0] key;
    logic [31:0] count;
    logic [63:0] total;
    logic [47:0] min;
    logic [47:0] max;
  } rec_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT,
    S_WRITE,
    S_DUMP,
    S_OUT
  } state_e;

  // memory request from the sequencer
  typedef struct packed {
    logic rd_en;
    logic we;
  } mem_ctl_t;

endpackage

// ===== design/kss_mem.sv =====
// record memory of the statistics table
// one write port and one registered read port; uses kss_pkg
module kss_mem #(
  parameter int unsigned DEPTH = 32,
  parameter int unsigned AW    = 5
) (
  input  logic             clk_i,
  input  kss_pkg::mem_ctl_t ctl_i,
  input  logic [AW-1:0]    raddr_i,
  input  logic [AW-1:0]    waddr_i,
  input  kss_pkg::rec_t    wdata_i,
  output kss_pkg::rec_t    rdata_o
);

  kss_pkg::rec_t mem_q [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (ctl_i.we) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (ctl_i.rd_en) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

// ===== design/keyed_size_stats_table_unit.sv =====
// top level of the keyed size statistics table
// sequencer over the record memory kss_mem; uses kss_pkg
//
// Records are kept sorted by ascending key in a one-port-read memory with a registered
// read port. A record transaction scans entries from the bottom, one read per cycle,
// until it meets a key not below its own or the end of the used entries, then either
// updates that entry in place or shifts the upper entries up by one (each moved entry
// is read, then written one place up) and writes the new record; a new key that finds
// the table full is dropped with a full status. A dump streams the used entries out one
// per cycle through the output register, held while the output is stalled. One
// transaction is worked at a time; the next input is taken once the result of the
// previous one is registered for output.
module keyed_size_stats_table_unit #(
  parameter int unsigned TABLE_DEPTH = 32,
  parameter int unsigned SIZE_BITS   = 48
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  kss_pkg::in_t   in_data_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output kss_pkg::out_t  out_data_o
);

  localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
  localparam logic [47:0] SIZE_MASK = 48'({64{1'b1}} >> (64 - SIZE_BITS));

  kss_pkg::state_e state_q, state_d;
  logic [CW-1:0]   used_q, used_d;
  logic [CW-1:0]   idx_q, idx_d;     // scan / shift / dump pointer
  logic [CW-1:0]   pos_q, pos_d;     // insertion point
  logic            phase_q, phase_d; // shift: read then write
  logic [63:0]     key_q;
  logic [47:0]     size_q;
  logic            dump_q;
  logic            ov_q, ov_d;
  kss_pkg::out_t   od_q, od_d;
  kss_pkg::out_t   res_q, res_d;     // result waiting for the output register
  logic            rd_pend_q, rd_pend_d;

  kss_pkg::mem_ctl_t ctl;
  logic [AW-1:0]   raddr, waddr;
  kss_pkg::rec_t   wdata, rdata, upd;
  logic            out_free;
  logic            accept;

  kss_mem #(.DEPTH(TABLE_DEPTH), .AW(AW)) u_mem (
    .clk_i   (clk_i),
    .ctl_i   (ctl),
    .raddr_i (raddr),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .rdata_o (rdata)
  );

  assign out_free    = !ov_q || !out_stall_i;
  assign in_stall_o  = !(state_q == kss_pkg::S_IDLE);
  assign accept      = in_valid_i && !in_stall_o;
  assign out_valid_o = ov_q;
  assign out_data_o  = od_q;

  // saturating update of a matched record
  logic [64:0] tot_sum;
  always_comb begin
    tot_sum     = {1'b0, rdata.total} + {17'd0, size_q};
    upd         = rdata;
    upd.count   = (rdata.count == 32'hFFFF_FFFF) ? rdata.count : rdata.count + 32'd1;
    upd.total   = tot_sum[64] ? 64'hFFFF_FFFF_FFFF_FFFF : tot_sum[63:0];
    upd.min     = (size_q < rdata.min) ? size_q : rdata.min;
    upd.max     = (size_q > rdata.max) ? size_q : rdata.max;
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      kss_pkg::S_IDLE: begin
        if (accept) begin
          if (in_data_i.func == kss_pkg::FN_DUMP) begin
            state_d = (used_q == '0) ? kss_pkg::S_OUT : kss_pkg::S_DUMP;
          end else begin
            state_d = (used_q == '0) ? kss_pkg::S_WRITE : kss_pkg::S_SCAN;
          end
        end
      end
      kss_pkg::S_SCAN: begin
        if (rd_pend_q) begin
          if (rdata.key == key_q) state_d = kss_pkg::S_OUT;
          else if (rdata.key > key_q) begin
            state_d = (used_q == CW'(TABLE_DEPTH)) ? kss_pkg::S_OUT : kss_pkg::S_SHIFT;
          end else if (idx_q == used_q) begin
            state_d = (used_q == CW'(TABLE_DEPTH)) ? kss_pkg::S_OUT : kss_pkg::S_WRITE;
          end
        end
      end
      kss_pkg::S_SHIFT: begin
        if (phase_q && idx_q == pos_q + CW'(1)) state_d = kss_pkg::S_WRITE;
      end
      kss_pkg::S_WRITE: state_d = kss_pkg::S_OUT;
      kss_pkg::S_DUMP: begin
        if (rd_pend_q && out_free && idx_q == used_q) state_d = kss_pkg::S_OUT;
      end
      kss_pkg::S_OUT: if (out_free) state_d = kss_pkg::S_IDLE;
      default: state_d = kss_pkg::S_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    idx_d     = idx_q;
    pos_d     = pos_q;
    phase_d   = phase_q;
    used_d    = used_q;
    ov_d      = ov_q && out_stall_i;
    od_d      = od_q;
    res_d     = res_q;
    rd_pend_d = 1'b0;
    ctl       = '0;
    raddr     = idx_q[AW-1:0];
    waddr     = idx_q[AW-1:0];
    wdata     = rdata;
    unique case (state_q)
      kss_pkg::S_IDLE: begin
        idx_d = '0;
        pos_d = used_q;
        if (accept && in_data_i.func == kss_pkg::FN_DUMP && used_q == '0) begin
          res_d = '0;
          res_d.status = kss_pkg::ST_EMPTY;
          res_d.last = 1'b1;
        end
      end
      kss_pkg::S_SCAN: begin
        if (!rd_pend_q || (rdata.key < key_q && idx_q != used_q)) begin
          ctl.rd_en = 1'b1;
          rd_pend_d = 1'b1;
          idx_d     = idx_q + CW'(1);
        end
        if (rd_pend_q) begin
          if (rdata.key == key_q) begin
            ctl.we = 1'b1;
            waddr  = AW'(idx_q - CW'(1));
            wdata  = upd;
            res_d  = '{kss_pkg::ST_UPD, upd.key, upd.count, upd.total,
                       upd.min, upd.max, 1'b1};
          end else if (rdata.key > key_q || idx_q == used_q) begin
            if (used_q == CW'(TABLE_DEPTH)) begin
              res_d = '0;
              res_d.status = kss_pkg::ST_FULL;
              res_d.entry_key = key_q;
              res_d.last = 1'b1;
            end
            pos_d   = (rdata.key > key_q) ? idx_q - CW'(1) : used_q;
            idx_d   = used_q;
            phase_d = 1'b0;
            ctl.rd_en = 1'b0;
            rd_pend_d = 1'b0;
          end
        end
      end
      kss_pkg::S_SHIFT: begin
        // read entry idx-1, then write it to idx
        if (!phase_q) begin
          ctl.rd_en = 1'b1;
          raddr     = AW'(idx_q - CW'(1));
          phase_d   = 1'b1;
        end else begin
          ctl.we  = 1'b1;
          wdata   = rdata;
          idx_d   = idx_q - CW'(1);
          phase_d = 1'b0;
        end
      end
      kss_pkg::S_WRITE: begin
        ctl.we = 1'b1;
        waddr  = pos_q[AW-1:0];
        wdata  = '{key_q, 32'd1, {16'd0, size_q}, size_q, size_q};
        used_d = used_q + CW'(1);
        res_d  = '{kss_pkg::ST_NEW, key_q, 32'd1, {16'd0, size_q}, size_q, size_q, 1'b1};
      end
      kss_pkg::S_DUMP: begin
        if (rd_pend_q) begin
          if (out_free) begin
            ov_d = 1'b1;
            od_d = '{kss_pkg::ST_DUMP, rdata.key, rdata.count, rdata.total,
                     rdata.min, rdata.max, idx_q == used_q};
          end else begin
            rd_pend_d = 1'b1;
          end
        end
        if (idx_q != used_q && (!rd_pend_q || out_free)) begin
          ctl.rd_en = 1'b1;
          rd_pend_d = 1'b1;
          idx_d     = idx_q + CW'(1);
        end
      end
      kss_pkg::S_OUT: begin
        // move the waiting result out once the output register frees up
        if (out_free && (!dump_q || used_q == '0)) begin
          ov_d = 1'b1;
          od_d = res_q;
        end
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= kss_pkg::S_IDLE;
      used_q    <= '0;
      ov_q      <= 1'b0;
      rd_pend_q <= 1'b0;
      idx_q     <= '0;
      pos_q     <= '0;
      phase_q   <= 1'b0;
    end else begin
      state_q   <= state_d;
      used_q    <= used_d;
      ov_q      <= ov_d;
      rd_pend_q <= rd_pend_d;
      idx_q     <= idx_d;
      pos_q     <= pos_d;
      phase_q   <= phase_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    od_q  <= od_d;
    res_q <= res_d;
    if (accept) begin
      key_q  <= in_data_i.stack_id;
      size_q <= in_data_i.chunk_size & SIZE_MASK;
      dump_q <= in_data_i.func == kss_pkg::FN_DUMP;
    end
  end

endmodule

// ===== tb/tb_keyed_size_stats_table_unit.sv =====
// testbench for keyed_size_stats_table_unit: directed and random record/dump traffic
// predicts results with a sorted key table in a scoreboard class; uses kss_pkg
module tb_keyed_size_stats_table_unit;

  localparam int DEPTH = 32;
  localparam int LIMIT = 400000;

  logic           clk_i = 1'b0;
  logic           rst_ni = 1'b0;
  logic           in_valid_i = 1'b0;
  logic           in_stall_o;
  kss_pkg::in_t   in_data_i = '0;
  logic           out_valid_o;
  logic           out_stall_i = 1'b0;
  kss_pkg::out_t  out_data_o;

  int    n_err = 0;
  int    cyc = 0;
  bit    calm = 1'b0;
  bit    hold_long = 1'b0;

  keyed_size_stats_table_unit #(.TABLE_DEPTH(DEPTH), .SIZE_BITS(48)) dut (.*);

  // print one mismatch line and count it
  task automatic report(input string what);
    n_err++;
    if (n_err < 40) $display("mismatch at cycle %0d: %s", cyc, what);
  endtask

  // sorted table predictor and queue of pending results
  class stats_board;
    logic [63:0]   keys[$];
    logic [31:0]   cnts[$];
    logic [63:0]   tots[$];
    logic [47:0]   mins[$];
    logic [47:0]   maxs[$];
    kss_pkg::out_t pending[$];

    function kss_pkg::out_t rec(kss_pkg::status_e st, int i, bit lst);
      kss_pkg::out_t r;
      r.status = st; r.entry_key = keys[i]; r.entry_count = cnts[i];
      r.entry_total = tots[i]; r.entry_min = mins[i]; r.entry_max = maxs[i];
      r.last = lst;
      return r;
    endfunction

    function void note_input(kss_pkg::in_t t);
      kss_pkg::out_t r;
      int p;
      logic [64:0] sum;
      if (t.func == kss_pkg::FN_DUMP) begin
        if (keys.size() == 0) begin
          r = '0; r.status = kss_pkg::ST_EMPTY; r.last = 1'b1; pending.push_back(r);
        end
        for (int i = 0; i < keys.size(); i++)
          pending.push_back(rec(kss_pkg::ST_DUMP, i, i == keys.size() - 1));
        return;
      end
      p = 0;
      while (p < keys.size() && keys[p] < t.stack_id) p++;
      if (p < keys.size() && keys[p] == t.stack_id) begin
        if (cnts[p] != '1) cnts[p]++;
        sum = {1'b0, tots[p]} + {17'd0, t.chunk_size};
        tots[p] = sum[64] ? '1 : sum[63:0];
        if (t.chunk_size < mins[p]) mins[p] = t.chunk_size;
        if (t.chunk_size > maxs[p]) maxs[p] = t.chunk_size;
        pending.push_back(rec(kss_pkg::ST_UPD, p, 1'b1));
      end else if (keys.size() >= DEPTH) begin
        r = '0; r.status = kss_pkg::ST_FULL; r.entry_key = t.stack_id; r.last = 1'b1;
        pending.push_back(r);
      end else begin
        keys.insert(p, t.stack_id); cnts.insert(p, 32'd1);
        tots.insert(p, {16'd0, t.chunk_size});
        mins.insert(p, t.chunk_size); maxs.insert(p, t.chunk_size);
        pending.push_back(rec(kss_pkg::ST_NEW, p, 1'b1));
      end
    endfunction

    task check_result(kss_pkg::out_t got);
      kss_pkg::out_t w;
      if (pending.size() == 0) begin
        report("result with nothing expected");
        return;
      end
      w = pending.pop_front();
      if (got.status !== w.status)
        report($sformatf("status %0d want %0d", got.status, w.status));
      if (got.entry_key !== w.entry_key)
        report($sformatf("key %h want %h", got.entry_key, w.entry_key));
      if (got.entry_count !== w.entry_count)
        report($sformatf("count %h want %h", got.entry_count, w.entry_count));
      if (got.entry_total !== w.entry_total)
        report($sformatf("total %h want %h", got.entry_total, w.entry_total));
      if (got.entry_min !== w.entry_min)
        report($sformatf("min %h want %h", got.entry_min, w.entry_min));
      if (got.entry_max !== w.entry_max)
        report($sformatf("max %h want %h", got.entry_max, w.entry_max));
      if (got.last !== w.last)
        report($sformatf("last %b want %b", got.last, w.last));
    endtask
  endclass

  stats_board board = new();

  // clock
  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // cycle counter with run limit
  always @(posedge clk_i) begin
    cyc <= cyc + 1;
    if (cyc > LIMIT) begin
      $display("FAIL keyed_size_stats_table_unit");
      $finish;
    end
  end

  // monitor: note accepted inputs and check accepted results
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && !in_stall_o) board.note_input(in_data_i);
    if (rst_ni && out_valid_o && !out_stall_i) board.check_result(out_data_o);
  end

  // receiver stall bursts
  initial begin
    int n;
    forever begin
      @(posedge clk_i);
      if (hold_long) begin
        out_stall_i <= 1'b1;
        repeat (300) @(posedge clk_i);
        out_stall_i <= 1'b0;
        hold_long = 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        n = $urandom_range(1, 16);
        out_stall_i <= 1'b1;
        repeat (n) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  // offer one transaction and wait for acceptance; valid stays up for the next one
  task automatic send(input kss_pkg::func_e f, input logic [63:0] k,
                      input logic [47:0] s);
    kss_pkg::in_t t;
    int gap;
    gap = 0;
    if (!calm && $urandom_range(0, 4) == 0) gap = $urandom_range(1, 16);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    t.func = f; t.stack_id = k; t.chunk_size = s;
    in_valid_i <= 1'b1;
    in_data_i <= t;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // stop offering and wait for every expected result
  task automatic drain();
    in_valid_i <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk_i);
    repeat (120) @(posedge clk_i);
  endtask

  function automatic logic [63:0] rnd64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [47:0] rnd_size();
    case ($urandom_range(0, 3))
      0: return '1;
      1: return 48'd0;
      2: return 48'({$urandom, $urandom}) & 48'hFFFF;
      default: return 48'({$urandom, $urandom});
    endcase
  endfunction

  logic [63:0] pool[8];

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty dump, extremes, repeated large sizes
    send(kss_pkg::FN_DUMP, rnd64(), rnd_size());
    send(kss_pkg::FN_RECORD, 64'd0, 48'd0);
    send(kss_pkg::FN_RECORD, '1, '1);
    send(kss_pkg::FN_RECORD, '1, '1);
    send(kss_pkg::FN_RECORD, '1, 48'd0);
    send(kss_pkg::FN_RECORD, 64'h8000_0000_0000_0000, 48'h1234);
    send(kss_pkg::FN_RECORD, 64'h8000_0000_0000_0000, 48'h5);
    send(kss_pkg::FN_RECORD, 64'h8000_0000_0000_0000, 48'h9999);
    for (int i = 0; i < 12; i++) send(kss_pkg::FN_RECORD, '1, '1);
    send(kss_pkg::FN_DUMP, '1, '1);
    drain();

    // fill table, then full drops, with a long output hold
    hold_long = 1'b1;
    for (int i = 0; i < 34; i++) send(kss_pkg::FN_RECORD, rnd64(), rnd_size());
    send(kss_pkg::FN_RECORD, 64'h1, 48'h77);
    send(kss_pkg::FN_DUMP, 64'd0, 48'd0);
    drain();

    // random: known keys updated, fresh keys dropped since table is full
    for (int i = 0; i < 8; i++) pool[i] = board.keys[$urandom_range(0, DEPTH - 1)];
    for (int i = 0; i < 110; i++) begin
      if (i > 85) calm = 1'b1;
      case ($urandom_range(0, 9))
        0: send(kss_pkg::FN_DUMP, rnd64(), rnd_size());
        1, 2: send(kss_pkg::FN_RECORD, rnd64(), rnd_size());
        default: send(kss_pkg::FN_RECORD, pool[$urandom_range(0, 7)], rnd_size());
      endcase
    end
    send(kss_pkg::FN_DUMP, 64'd0, 48'd0);

    drain();
    if (n_err == 0) begin
      $display("PASS keyed_size_stats_table_unit");
    end else begin
      $display("FAIL keyed_size_stats_table_unit");
    end
    $finish;
  end
endmodule
